[rtl/fxalu_pkg.sv]
// ----------------------------------------------------------------------------
// fxalu_pkg: shared types and helpers for the Q24.8 fixed-point ALU
// Opcodes, the item that travels down the divider chain, and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package fxalu_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int FRAC_MAX      = 16;
  localparam int NUM_W         = 32 + FRAC_MAX;

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MUL    = 4'd2,
    OP_DIV    = 4'd3,
    OP_LT     = 4'd4,
    OP_LE     = 4'd5,
    OP_GT     = 4'd6,
    OP_GE     = 4'd7,
    OP_EQ     = 4'd8,
    OP_NE     = 4'd9,
    OP_MIN    = 4'd10,
    OP_MAX    = 4'd11,
    OP_INC    = 4'd12,
    OP_DEC    = 4'd13,
    OP_TO_INT = 4'd14
  } op_t;

  typedef struct packed {
    logic             vld;
    logic [3:0]       op;
    logic [31:0]      value;
    logic             cmp;
    logic             ov;
    logic             dz;
    logic             neg;
    logic [31:0]      den;
    logic [NUM_W-1:0] num;
    logic [31:0]      rem;
    logic [NUM_W-1:0] quot;
  } item_t;

  typedef struct packed {
    logic [31:0] value;
    logic        ov;
  } sat_t;

  // Applies a sign to an unsigned magnitude and saturates to 32 bits.
  function automatic sat_t sat_mag(input logic neg, input logic [64:0] mag);
    sat_t r;
    r.ov = 1'b0;
    if (neg) begin
      if (mag > 65'h0_8000_0000) begin
        r.ov    = 1'b1;
        r.value = 32'h8000_0000;
      end else begin
        r.value = 32'(~mag[31:0] + 32'd1);
      end
    end else begin
      if (mag > 65'h0_7FFF_FFFF) begin
        r.ov    = 1'b1;
        r.value = 32'h7FFF_FFFF;
      end else begin
        r.value = mag[31:0];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/fxalu_div_cell.sv]
// ----------------------------------------------------------------------------
// fxalu_div_cell: one restoring division step of the divider chain
// Takes one dividend bit, produces one quotient bit, and registers the item.
// ----------------------------------------------------------------------------
`default_nettype none

module fxalu_div_cell (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 en,
  input  fxalu_pkg::item_t    item_in,
  output fxalu_pkg::item_t    item_out
);
  import fxalu_pkg::*;

  item_t       item_next;
  logic [32:0] trial;
  logic        fits;

  always_comb begin
    item_next = item_in;
    trial     = {item_in.rem, item_in.num[NUM_W-1]};
    fits      = trial >= {1'b0, item_in.den};
    item_next.num  = {item_in.num[NUM_W-2:0], 1'b0};
    item_next.quot = {item_in.quot[NUM_W-2:0], fits};
    // For a nonzero divisor the remainder stays below it, so 32 bits suffice.
    item_next.rem  = fits ? 32'(trial - {1'b0, item_in.den}) : trial[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_out.vld <= 1'b0;
    end else if (en) begin
      item_out <= item_next;
    end
  end

endmodule

`default_nettype wire

[rtl/fixed_point_alu_q24_8.sv]
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8: signed fixed-point ALU on raw 32-bit operands
// Add, subtract, exact rounded multiply and divide, compares, min/max,
// inc/dec and integer conversion, with saturation and a divide-by-zero flag.
// ----------------------------------------------------------------------------
//  channel | signals                                       | direction
//  in      | in_valid, in_stall, op, operand_a, operand_b  | request in
//  out     | out_valid, out_stall, value, compare_true,    | result out
//          | overflowed, divide_by_zero                    |
//
// One request is taken per cycle while in_stall is low. Whatever its op, a
// request passes through the operand register, the register after the
// multiplier, a row of 32 + FRAC_BITS division cells that produce one
// quotient bit each, and the output register.
// Reset empties the pipeline. While a result waits under out_stall the whole
// pipeline freezes, and in_stall is raised for exactly those cycles.
`default_nettype none

module fixed_point_alu_q24_8 #(
  parameter int FRAC_BITS = fxalu_pkg::FRAC_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [3:0]  op,
  input  wire  [31:0] operand_a,
  input  wire  [31:0] operand_b,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] value,
  output logic        compare_true,
  output logic        overflowed,
  output logic        divide_by_zero
);
  import fxalu_pkg::*;

  localparam int N_CELLS = 32 + FRAC_BITS;

  logic        en;
  logic        s1_vld;
  logic [3:0]  s1_op;
  logic [31:0] s1_a;
  logic [31:0] s1_b;
  item_t       s1_item;
  logic [63:0] s1_prod;
  item_t       s2_item;
  logic [63:0] s2_prod;
  item_t       chain [0:N_CELLS];
  logic [64:0] mul_sum;
  logic [64:0] mul_mag;
  sat_t        mul_sat;
  logic        rnd_up;
  logic [48:0] div_q;
  sat_t        div_sat;
  item_t       last;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op <= op;
      s1_a  <= operand_a;
      s1_b  <= operand_b;
    end
  end

  // First stage: everything but the multiply and divide results.
  always_comb begin
    logic signed [32:0] sum;
    logic signed [31:0] sa;
    logic signed [31:0] sb;
    logic [31:0]        a_mag;
    logic [31:0]        b_mag;
    logic               lt;
    sa    = signed'(s1_a);
    sb    = signed'(s1_b);
    lt    = sa < sb;
    a_mag = s1_a[31] ? 32'(~s1_a + 32'd1) : s1_a;
    b_mag = s1_b[31] ? 32'(~s1_b + 32'd1) : s1_b;
    sum   = '0;
    s1_item       = '0;
    s1_item.vld   = s1_vld;
    s1_item.op    = s1_op;
    s1_item.neg   = s1_a[31] ^ s1_b[31];
    s1_item.den   = b_mag;
    s1_item.num   = {a_mag, {FRAC_MAX{1'b0}}};
    s1_prod       = a_mag * b_mag;
    case (s1_op)
      OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
        case (s1_op)
          OP_ADD:  sum = 33'(sa) + 33'(sb);
          OP_SUB:  sum = 33'(sa) - 33'(sb);
          OP_INC:  sum = 33'(sa) + 33'sd1;
          default: sum = 33'(sa) - 33'sd1;
        endcase
        if (sum[32] != sum[31]) begin
          s1_item.ov    = 1'b1;
          s1_item.value = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
          s1_item.value = sum[31:0];
        end
      end
      OP_DIV: begin
        if (s1_b == 32'd0) begin
          s1_item.dz    = 1'b1;
          s1_item.value = s1_a[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
      end
      OP_LT: s1_item.cmp = lt;
      OP_LE: s1_item.cmp = lt || (s1_a == s1_b);
      OP_GT: s1_item.cmp = !lt && (s1_a != s1_b);
      OP_GE: s1_item.cmp = !lt;
      OP_EQ: s1_item.cmp = s1_a == s1_b;
      OP_NE: s1_item.cmp = s1_a != s1_b;
      OP_MIN: s1_item.value = lt ? s1_a : s1_b;
      OP_MAX: s1_item.value = (!lt && (s1_a != s1_b)) ? s1_a : s1_b;
      OP_TO_INT: begin
        // Bias negative values so the arithmetic shift truncates toward zero.
        s1_item.value = 32'((sa + (s1_a[31] ? 32'sd0 + ((32'sd1 <<< FRAC_BITS) - 32'sd1)
                                             : 32'sd0)) >>> FRAC_BITS);
      end
      default: s1_item.value = '0;
    endcase
    if (s1_item.cmp) begin
      s1_item.value = 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_item.vld <= 1'b0;
    end else if (en) begin
      s2_item <= s1_item;
      s2_prod <= s1_prod;
    end
  end

  generate
    if (FRAC_BITS > 0) begin : g_rnd
      assign mul_sum = {1'b0, s2_prod} + (65'd1 << (FRAC_BITS - 1));
    end else begin : g_nornd
      assign mul_sum = {1'b0, s2_prod};
    end
  endgenerate

  assign mul_mag = mul_sum >> FRAC_BITS;
  assign mul_sat = sat_mag(s2_item.neg, mul_mag);

  always_comb begin
    chain[0] = s2_item;
    if (s2_item.op == OP_MUL) begin
      chain[0].value = mul_sat.value;
      chain[0].ov    = mul_sat.ov;
    end
  end

  generate
    for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
      fxalu_div_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .en       (en),
        .item_in  (chain[i]),
        .item_out (chain[i+1])
      );
    end
  endgenerate

  assign last = chain[N_CELLS];

  // Round half away from zero: step up when twice the remainder reaches the divisor.
  assign rnd_up  = {last.rem, 1'b0} >= {1'b0, last.den};
  assign div_q   = {1'b0, last.quot} + 49'(rnd_up);
  assign div_sat = sat_mag(last.neg, {16'd0, div_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= last.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (last.op == OP_DIV && !last.dz) begin
        value      <= div_sat.value;
        overflowed <= div_sat.ov;
      end else begin
        value      <= last.value;
        overflowed <= last.ov;
      end
      compare_true   <= last.cmp;
      divide_by_zero <= last.dz;
    end
  end

  a_dz_no_ov: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(divide_by_zero && overflowed))
    else $error("divide by zero reported together with overflow");

  a_cmp_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && compare_true) |-> (value == 32'd1))
    else $error("true comparison without a value of one");

  a_ov_sat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflowed) |-> (value == 32'h7FFF_FFFF || value == 32'h8000_0000))
    else $error("overflow without a saturated value");

  a_stall_back: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow the output stall");

endmodule

`default_nettype wire

[verif/fxalu_checker.sv]
// ----------------------------------------------------------------------------
// fxalu_checker: result predictor and scoreboard for the Q24.8 ALU
// Watches both channels, predicts each accepted request's result and compares
// every accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fxalu_checker #(
  parameter int FRAC_BITS = 8
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  input  wire         in_stall,
  input  wire  [3:0]  op,
  input  wire  [31:0] operand_a,
  input  wire  [31:0] operand_b,
  input  wire         out_valid,
  input  wire         out_stall,
  input  wire  [31:0] value,
  input  wire         compare_true,
  input  wire         overflowed,
  input  wire         divide_by_zero,
  output int          error_count,
  output int          pending_count
);
  import fxalu_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic        cmp;
    logic        ov;
    logic        dz;
  } alu_result_t;

  alu_result_t expected_results[$];

  // Saturates an exact signed value into 32 bits.
  function automatic alu_result_t clamp_result(input longint v);
    alu_result_t r;
    r = '0;
    if (v > 64'sd2147483647) begin
      r.value = 32'h7FFF_FFFF;
      r.ov    = 1'b1;
    end else if (v < -64'sd2147483648) begin
      r.value = 32'h8000_0000;
      r.ov    = 1'b1;
    end else begin
      r.value = v[31:0];
    end
    return r;
  endfunction

  function automatic alu_result_t predict_alu(input logic [3:0] code,
                                              input logic [31:0] ra,
                                              input logic [31:0] rb);
    alu_result_t r;
    longint a, b, signed_q;
    logic [63:0] mag_a, mag_b;
    logic [127:0] prod, num, den;
    logic negative;
    r = '0;
    a = longint'(signed'(ra));
    b = longint'(signed'(rb));
    mag_a = a < 0 ? 64'(-a) : 64'(a);
    mag_b = b < 0 ? 64'(-b) : 64'(b);
    negative = (a < 0) != (b < 0);
    case (code)
      OP_ADD: r = clamp_result(a + b);
      OP_SUB: r = clamp_result(a - b);
      OP_MUL: begin
        prod = 128'(mag_a) * 128'(mag_b);
        if (FRAC_BITS > 0) prod = (prod + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        signed_q = negative ? -longint'(prod[63:0]) : longint'(prod[63:0]);
        r = clamp_result(prod > 128'h8000_0000 ? (negative ? -64'sd3000000000
                                                           : 64'sd3000000000)
                                               : signed_q);
      end
      OP_DIV: begin
        if (b == 0) begin
          r.dz    = 1'b1;
          r.value = a >= 0 ? 32'h7FFF_FFFF : 32'h8000_0000;
        end else begin
          num = 128'(mag_a) << FRAC_BITS;
          den = 128'(mag_b);
          prod = (2 * num + den) / (2 * den);
          signed_q = negative ? -longint'(prod[63:0]) : longint'(prod[63:0]);
          r = clamp_result(prod > 128'h8000_0000 ? (negative ? -64'sd3000000000
                                                             : 64'sd3000000000)
                                                 : signed_q);
        end
      end
      OP_LT: r.cmp = a < b;
      OP_LE: r.cmp = a <= b;
      OP_GT: r.cmp = a > b;
      OP_GE: r.cmp = a >= b;
      OP_EQ: r.cmp = a == b;
      OP_NE: r.cmp = a != b;
      OP_MIN: r.value = a < b ? ra : rb;
      OP_MAX: r.value = a > b ? ra : rb;
      OP_INC: r = clamp_result(a + 1);
      OP_DEC: r = clamp_result(a - 1);
      OP_TO_INT: begin
        signed_q = a / (64'sd1 <<< FRAC_BITS);
        r.value = signed_q[31:0];
      end
      default: r = '0;
    endcase
    if (code >= OP_LT && code <= OP_NE) r.value = {31'd0, r.cmp};
    return r;
  endfunction

  always @(posedge clk) begin
    alu_result_t exp_r;
    int          errs;
    errs = 0;
    if (rst) begin
      error_count <= 0;
      expected_results.delete();
      pending_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_results.push_back(predict_alu(op, operand_a, operand_b));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: value %h", value);
          errs = errs + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (value !== exp_r.value) begin
            $error("value: expected %h, got %h", exp_r.value, value);
            errs = errs + 1;
          end
          if (compare_true !== exp_r.cmp) begin
            $error("compare_true: expected %b, got %b", exp_r.cmp, compare_true);
            errs = errs + 1;
          end
          if (overflowed !== exp_r.ov) begin
            $error("overflowed: expected %b, got %b", exp_r.ov, overflowed);
            errs = errs + 1;
          end
          if (divide_by_zero !== exp_r.dz) begin
            $error("divide_by_zero: expected %b, got %b", exp_r.dz, divide_by_zero);
            errs = errs + 1;
          end
        end
      end
      error_count   <= error_count + errs;
      pending_count <= expected_results.size();
    end
  end

endmodule

`default_nettype wire

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the Q24.8 fixed-point ALU
// Directed corner requests, then random ones under several idling phases;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import fxalu_pkg::*;

  localparam int FRAC_BITS = 8;
  localparam int LATENCY   = 35 + FRAC_BITS;
  localparam int WATCHDOG  = 4000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  op = '0;
  logic [31:0] operand_a = '0;
  logic [31:0] operand_b = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] value;
  logic        compare_true;
  logic        overflowed;
  logic        divide_by_zero;
  int          error_count;
  int          pending_count;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;

  always #5 clk = ~clk;

  fixed_point_alu_q24_8 #(.FRAC_BITS(FRAC_BITS)) i_dut (
    .clk, .rst, .in_valid, .in_stall, .op, .operand_a, .operand_b,
    .out_valid, .out_stall, .value, .compare_true, .overflowed, .divide_by_zero
  );

  fxalu_checker #(.FRAC_BITS(FRAC_BITS)) i_checker (
    .clk, .rst, .in_valid, .in_stall, .op, .operand_a, .operand_b,
    .out_valid, .out_stall, .value, .compare_true, .overflowed, .divide_by_zero,
    .error_count, .pending_count
  );

  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  // Counts cycles with no accepted request or result.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF - $urandom_range(2);
      1: return 32'h8000_0000 + $urandom_range(2);
      2: return 32'($urandom_range(4)) - 32'd2;
      3: return 32'($urandom_range(65535)) - 32'd32768;
      4: return {{16{1'b0}}, 16'($urandom)} << $urandom_range(12);
      default: return $urandom;
    endcase
  endfunction

  // Presents one request and holds it until the block takes it. Valid stays
  // high afterwards; the next call either replaces the request or drops valid.
  task automatic send_request(input logic [3:0] code, input logic [31:0] ra,
                              input logic [31:0] rb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    op        <= code;
    operand_a <= ra;
    operand_b <= rb;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_count != 0) @(negedge clk);
  endtask

  initial begin
    logic [31:0] a_vals[6];
    logic [31:0] rb;
    a_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h100, 32'hFFFF_FF80, 32'h180};
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: every op, range ends, zero divisor, ties and rounding halves.
    for (int k = 0; k < 16; k++)
      send_request(4'(k), a_vals[k % 6], a_vals[(k + 2) % 6]);
    send_request(OP_DIV, 32'h8000_0000, 32'h0);
    send_request(OP_DIV, 32'h7FFF_FFFF, 32'h0);
    send_request(OP_DIV, 32'h8000_0000, 32'hFFFF_FF00);
    send_request(OP_MUL, 32'h8000_0000, 32'h8000_0000);
    send_request(OP_MUL, 32'h0000_0080, 32'hFFFF_FF01);
    send_request(OP_MIN, 32'h5, 32'h5);
    send_request(OP_MAX, 32'hFFFF_FFF0, 32'hFFFF_FFF0);
    send_request(OP_TO_INT, 32'hFFFF_FF01, 32'h0);
    send_request(OP_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    in_valid <= 1'b0;
    // The sender waits here until every outstanding result has come back.
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 66 : 10) : 0;
      stall_pct     = (phase == 2 || phase == 3) ? (phase == 2 ? 66 : 10) : 0;
      for (int n = 0; n < 256; n++) begin
        rb = $urandom_range(7) == 0 ? 32'h0 : pick_operand();
        send_request(4'($urandom_range(15)), pick_operand(), rb);
      end
    end
    in_valid <= 1'b0;
    stall_pct = 0;

    wait_drained();
    repeat (LATENCY + 10) @(negedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
